// File: sv/mpva_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the polyphonic voice allocator; no dependencies
package mpva_pkg;

    localparam int MAX_VOICES_DEF = 16;
    localparam int HELD_DEPTH_DEF = 128;
    localparam int NUM_CHANNELS   = 16;
    localparam int NOTE_COUNT     = 128;

    localparam logic [6:0]  NOTE_CENTER = 7'd60;
    localparam logic [13:0] BEND_CENTER = 14'd8192;
    localparam logic [6:0]  CC_MOD      = 7'h01;
    localparam logic [6:0]  CC_PEDAL    = 7'h40;
    localparam logic [6:0]  CC_ALL_OFF  = 7'h7B;
    localparam logic [6:0]  PEDAL_ON    = 7'd64;
    localparam logic [7:0]  SYS_FIRST   = 8'hF0;

    // status high nibbles
    localparam logic [3:0] MSG_OFF  = 4'h8;
    localparam logic [3:0] MSG_ON   = 4'h9;
    localparam logic [3:0] MSG_KEYP = 4'hA;
    localparam logic [3:0] MSG_CC   = 4'hB;
    localparam logic [3:0] MSG_CHP  = 4'hD;
    localparam logic [3:0] MSG_BEND = 4'hE;
    localparam logic [3:0] MSG_SYS  = 4'hF;

    // system low nibbles
    localparam logic [3:0] SYS_START = 4'hA;
    localparam logic [3:0] SYS_CONT  = 4'hB;
    localparam logic [3:0] SYS_STOP  = 4'hC;

    // register indexes
    localparam logic [1:0] REG_FILTER = 2'd0;
    localparam logic [1:0] REG_VOICES = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;
    localparam logic [1:0] REG_GAPS   = 2'd3;

    // poly modes
    localparam logic [1:0] MODE_ROTATE = 2'd0;
    localparam logic [1:0] MODE_REUSE  = 2'd1;
    localparam logic [1:0] MODE_RESET  = 2'd2;
    localparam logic [1:0] MODE_MPE    = 2'd3;

    // message kinds seen by the controller
    localparam logic [2:0] KIND_DROP   = 3'd0;
    localparam logic [2:0] KIND_ON     = 3'd1;
    localparam logic [2:0] KIND_OFF    = 3'd2;
    localparam logic [2:0] KIND_PEDUP  = 3'd3;
    localparam logic [2:0] KIND_SIMPLE = 3'd4;

    // datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LATCH    = 5'd1;
    localparam logic [4:0] OP_APPLY    = 5'd2;
    localparam logic [4:0] OP_RM_INIT  = 5'd3;
    localparam logic [4:0] OP_RM_RD    = 5'd4;
    localparam logic [4:0] OP_RM_CHK   = 5'd5;
    localparam logic [4:0] OP_RM_DONE  = 5'd6;
    localparam logic [4:0] OP_PUSH     = 5'd7;
    localparam logic [4:0] OP_PICK     = 5'd8;
    localparam logic [4:0] OP_ROT      = 5'd9;
    localparam logic [4:0] OP_VSET     = 5'd10;
    localparam logic [4:0] OP_REL      = 5'd11;
    localparam logic [4:0] OP_TOP_RD   = 5'd12;
    localparam logic [4:0] OP_TOP_WR   = 5'd13;
    localparam logic [4:0] OP_PED_INIT = 5'd14;
    localparam logic [4:0] OP_PED      = 5'd15;
    localparam logic [4:0] OP_REC_INIT = 5'd16;
    localparam logic [4:0] OP_REC      = 5'd17;

    typedef struct packed {
        logic [4:0] op;
        logic       first;   // stack removal drops the oldest entry
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       rm_skip;
        logic       rm_last;
        logic       full;
        logic       pick_direct;
        logic       rot_done;
        logic       rel_top;
        logic       pedal;
        logic       mono;
        logic       top_avail;
        logic       loop_last;
    } stat_t;

endpackage

// File: sv/midi_poly_voice_allocator.sv
// top level of the midi polyphonic voice allocator
// depends on mpva_pkg, mpva_ctrl, mpva_dp (which holds mpva_ram)
//
// usage:
// - message channel: drive status_byte, data_first, data_second with start
//   high; the message transfers at a clock edge where start is high and busy
//   is low. busy stays high until the last voice record has been sent
// - result channel: one record per active voice, voice 0 first, each shown
//   for exactly one cycle with result_strobe high; last marks the final one.
//   the receiver cannot stall, records are never held
// - config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   only while idle. changing voice count or mode clears performance state
// - timing: records come at one per cycle. note on/off walk the held-note
//   stack in its ram, at most one walk per message (a full stack drops its
//   oldest entry only when the note was not held), and rotate allocation
//   steps one voice per cycle; a pedal release also walks the active
//   voices. filtered messages give no records
// - reset: registers and all voice state go to their defaults at once;
//   the stack ram needs no clearing since only entries below its count are read
module midi_poly_voice_allocator #(
    parameter int MAX_VOICES = mpva_pkg::MAX_VOICES_DEF,
    parameter int HELD_DEPTH = mpva_pkg::HELD_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // message channel
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  status_byte,
    input  logic [6:0]  data_first,
    input  logic [6:0]  data_second,
    // config channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    // result channel
    output logic        result_strobe,
    output logic [3:0]  voice,
    output logic [6:0]  note_number,
    output logic        gate_on,
    output logic [6:0]  note_velocity,
    output logic [6:0]  pressure,
    output logic [13:0] bend,
    output logic [6:0]  modulation,
    output logic        start_event,
    output logic        stop_event,
    output logic        continue_event,
    output logic        last
);

    mpva_pkg::cmd_t  cmd;
    mpva_pkg::stat_t stat;

    // config only while no message is in progress
    assign cfg_ready = !busy;

    mpva_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mpva_dp #(
        .MAX_VOICES (MAX_VOICES),
        .HELD_DEPTH (HELD_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (stat),
        .status_byte    (status_byte),
        .data_first     (data_first),
        .data_second    (data_second),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_strobe  (result_strobe),
        .voice          (voice),
        .note_number    (note_number),
        .gate_on        (gate_on),
        .note_velocity  (note_velocity),
        .pressure       (pressure),
        .bend           (bend),
        .modulation     (modulation),
        .start_event    (start_event),
        .stop_event     (stop_event),
        .continue_event (continue_event),
        .last           (last)
    );

endmodule

// File: sv/mpva_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module mpva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/mpva_ctrl.sv
// sequencing state machine of the voice allocator
// depends on mpva_pkg
module mpva_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mpva_pkg::stat_t st,
    output mpva_pkg::cmd_t  cmd,
    output logic           busy
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_RMI   = 5'd2;
    localparam logic [4:0] S_RMR   = 5'd3;
    localparam logic [4:0] S_RMC   = 5'd4;
    localparam logic [4:0] S_RMX   = 5'd5;
    localparam logic [4:0] S_ONCHK = 5'd6;
    localparam logic [4:0] S_PUSH  = 5'd7;
    localparam logic [4:0] S_PICK  = 5'd8;
    localparam logic [4:0] S_ROT   = 5'd9;
    localparam logic [4:0] S_VSET  = 5'd10;
    localparam logic [4:0] S_REL   = 5'd11;
    localparam logic [4:0] S_TOPR  = 5'd12;
    localparam logic [4:0] S_TOPW  = 5'd13;
    localparam logic [4:0] S_PEDI  = 5'd14;
    localparam logic [4:0] S_PED   = 5'd15;
    localparam logic [4:0] S_RINIT = 5'd16;
    localparam logic [4:0] S_REC   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        cmd.op     = mpva_pkg::OP_NONE;
        cmd.first  = first_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = mpva_pkg::OP_LATCH;
                    first_next = 1'b0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (st.kind)
                    mpva_pkg::KIND_DROP:  state_next = S_IDLE;
                    mpva_pkg::KIND_ON:    state_next = S_RMI;
                    mpva_pkg::KIND_OFF:   state_next = S_RMI;
                    mpva_pkg::KIND_PEDUP: state_next = S_PEDI;
                    default:
                    begin
                        cmd.op     = mpva_pkg::OP_APPLY;
                        state_next = S_RINIT;
                    end
                endcase
            end
            S_RMI:
            begin
                cmd.op     = mpva_pkg::OP_RM_INIT;
                state_next = st.rm_skip ? S_RMX : S_RMR;
            end
            S_RMR:
            begin
                cmd.op     = mpva_pkg::OP_RM_RD;
                state_next = S_RMC;
            end
            S_RMC:
            begin
                cmd.op     = mpva_pkg::OP_RM_CHK;
                state_next = st.rm_last ? S_RMX : S_RMR;
            end
            S_RMX:
            begin
                cmd.op     = mpva_pkg::OP_RM_DONE;
                state_next = (st.kind == mpva_pkg::KIND_ON) ? S_ONCHK : S_REL;
            end
            S_ONCHK:
            begin
                // stack full: drop the oldest entry before the push
                if (st.full)
                begin
                    first_next = 1'b1;
                    state_next = S_RMI;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.op     = mpva_pkg::OP_PUSH;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.op     = mpva_pkg::OP_PICK;
                state_next = st.pick_direct ? S_VSET : S_ROT;
            end
            S_ROT:
            begin
                cmd.op = mpva_pkg::OP_ROT;
                if (st.rot_done)
                begin
                    state_next = S_VSET;
                end
            end
            S_VSET:
            begin
                cmd.op     = mpva_pkg::OP_VSET;
                state_next = S_RINIT;
            end
            S_REL:
            begin
                cmd.op     = mpva_pkg::OP_REL;
                state_next = st.rel_top ? S_TOPR : S_RINIT;
            end
            S_TOPR:
            begin
                cmd.op     = mpva_pkg::OP_TOP_RD;
                state_next = S_TOPW;
            end
            S_TOPW:
            begin
                cmd.op     = mpva_pkg::OP_TOP_WR;
                state_next = S_RINIT;
            end
            S_PEDI:
            begin
                if (!st.pedal)
                begin
                    state_next = S_RINIT;
                end
                else
                begin
                    cmd.op = mpva_pkg::OP_PED_INIT;
                    if (st.mono)
                    begin
                        state_next = st.top_avail ? S_TOPR : S_RINIT;
                    end
                    else
                    begin
                        state_next = S_PED;
                    end
                end
            end
            S_PED:
            begin
                cmd.op = mpva_pkg::OP_PED;
                if (st.loop_last)
                begin
                    state_next = S_RINIT;
                end
            end
            S_RINIT:
            begin
                cmd.op     = mpva_pkg::OP_REC_INIT;
                state_next = S_REC;
            end
            S_REC:
            begin
                cmd.op = mpva_pkg::OP_REC;
                if (st.loop_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/mpva_dp.sv
// datapath of the voice allocator: registers, voice state, held-note stack
// depends on mpva_pkg and mpva_ram
module mpva_dp #(
    parameter int MAX_VOICES = mpva_pkg::MAX_VOICES_DEF,
    parameter int HELD_DEPTH = mpva_pkg::HELD_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mpva_pkg::cmd_t  cmd,
    output mpva_pkg::stat_t st,
    input  logic [7:0]      status_byte,
    input  logic [6:0]      data_first,
    input  logic [6:0]      data_second,
    input  logic            cfg_wr,
    input  logic [1:0]      cfg_index,
    input  logic [4:0]      cfg_data,
    output logic            result_strobe,
    output logic [3:0]      voice,
    output logic [6:0]      note_number,
    output logic            gate_on,
    output logic [6:0]      note_velocity,
    output logic [6:0]      pressure,
    output logic [13:0]     bend,
    output logic [6:0]      modulation,
    output logic            start_event,
    output logic            stop_event,
    output logic            continue_event,
    output logic            last
);

    localparam int NCH = mpva_pkg::NUM_CHANNELS;
    localparam int IW  = $clog2(HELD_DEPTH);
    localparam int CW  = $clog2(HELD_DEPTH + 1);
    localparam logic [4:0] MAXV     = 5'(MAX_VOICES);
    localparam logic [4:0] PTR_NONE = 5'h1F;
    localparam logic [CW-1:0] FULL_COUNT = CW'(HELD_DEPTH);

    // configuration
    logic [4:0] filter_reg, vcount_reg;
    logic [1:0] mode_reg;
    logic       gaps_reg;

    // latched message
    logic [7:0] st_reg;
    logic [6:0] d1_reg, d2_reg;

    // performance state
    logic [6:0]  vn_reg   [NCH];
    logic [6:0]  vel_reg  [NCH];
    logic [6:0]  prs_reg  [NCH];
    logic [13:0] bnd_reg  [NCH];
    logic [6:0]  mod_reg  [NCH];
    logic [NCH-1:0] gate_reg, gap_reg;
    logic        pedal_reg;
    logic [4:0]  ptr_reg;
    logic [CW-1:0] count_reg;
    logic [mpva_pkg::NOTE_COUNT-1:0] held_reg;

    // sequencing
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic [6:0]    removed_reg;
    logic [3:0]    cnt_reg;
    logic [4:0]    rot_reg;
    logic [3:0]    vsel_reg;

    logic [4:0] n_act;
    logic       mpe;
    logic [3:0] chan;
    logic [2:0] kind;
    logic [NCH-1:0] vmatch, vact;
    logic [3:0] free_idx, reuse_idx;
    logic       reuse_any;
    logic [4:0] rot_step;
    logic [5:0] ptr_inc;
    logic       clr_perf, clr_wheels;
    logic       ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [6:0] ram_wdata, ram_q;
    logic       is_match;
    logic [3:0] w_idx;

    mpva_ram #(
        .WIDTH (7),
        .DEPTH (HELD_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign chan = st_reg[3:0];
    assign mpe  = (mode_reg == mpva_pkg::MODE_MPE);

    always_comb
    begin
        if (vcount_reg == 5'd0)
        begin
            n_act = 5'd1;
        end
        else if (vcount_reg > MAXV)
        begin
            n_act = MAXV;
        end
        else
        begin
            n_act = vcount_reg;
        end
    end

    // message classification
    always_comb
    begin
        if (filter_reg != 5'd0 && st_reg < mpva_pkg::SYS_FIRST
            && ({1'b0, chan} + 5'd1) != filter_reg)
        begin
            kind = mpva_pkg::KIND_DROP;
        end
        else
        begin
            case (st_reg[7:4])
                mpva_pkg::MSG_OFF: kind = mpva_pkg::KIND_OFF;
                mpva_pkg::MSG_ON:
                    kind = (d2_reg != 7'd0) ? mpva_pkg::KIND_ON : mpva_pkg::KIND_OFF;
                mpva_pkg::MSG_CC:
                    kind = (d1_reg == mpva_pkg::CC_PEDAL && d2_reg < mpva_pkg::PEDAL_ON)
                           ? mpva_pkg::KIND_PEDUP : mpva_pkg::KIND_SIMPLE;
                default: kind = mpva_pkg::KIND_SIMPLE;
            endcase
        end
    end

    // parallel compares over the voices and priority picks
    always_comb
    begin
        free_idx  = 4'(n_act - 5'd1);
        reuse_idx = 4'd0;
        reuse_any = 1'b0;
        for (int c = NCH - 1; c >= 0; c--)
        begin
            vmatch[c] = (vn_reg[c] == d1_reg);
            vact[c]   = (5'(c) < n_act);
            if (vact[c] && !gate_reg[c])
            begin
                free_idx = 4'(c);
            end
            if (vact[c] && vmatch[c])
            begin
                reuse_idx = 4'(c);
                reuse_any = 1'b1;
            end
        end
    end

    assign ptr_inc  = {1'b0, ptr_reg} + 6'd1;
    assign rot_step = (ptr_reg == PTR_NONE || ptr_inc >= {1'b0, n_act}) ? 5'd0 : ptr_inc[4:0];
    assign is_match = !found_reg && (cmd.first ? (idx_reg == '0) : (ram_q == d1_reg));
    assign w_idx    = mpe ? cnt_reg : 4'd0;

    always_comb
    begin
        st.kind      = kind;
        st.rm_skip   = (count_reg == '0) || (!cmd.first && !held_reg[d1_reg]);
        st.rm_last   = (CW'(idx_reg) + CW'(1)) == count_reg;
        st.full      = (count_reg >= FULL_COUNT);
        st.pick_direct = mpe || (n_act == 5'd1) || (mode_reg == mpva_pkg::MODE_RESET)
                         || (mode_reg == mpva_pkg::MODE_REUSE && reuse_any);
        st.rot_done  = !gate_reg[rot_step[3:0]] || (rot_reg == n_act);
        st.rel_top   = !pedal_reg && (n_act == 5'd1) && (d1_reg == vn_reg[0])
                       && (count_reg != '0);
        st.pedal     = pedal_reg;
        st.mono      = (n_act == 5'd1);
        st.top_avail = (count_reg != '0);
        st.loop_last = ({1'b0, cnt_reg} == n_act - 5'd1);
    end

    // stack memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg - IW'(1);
        ram_wdata = ram_q;
        ram_raddr = idx_reg;
        case (cmd.op)
            mpva_pkg::OP_RM_CHK: ram_we = found_reg;
            mpva_pkg::OP_PUSH:
            begin
                ram_we    = 1'b1;
                ram_waddr = count_reg[IW-1:0];
                ram_wdata = d1_reg;
            end
            mpva_pkg::OP_TOP_RD: ram_raddr = IW'(count_reg - CW'(1));
            default: ram_we = 1'b0;
        endcase
    end

    assign clr_wheels = cfg_wr
        && ((cfg_index == mpva_pkg::REG_VOICES && cfg_data != vcount_reg)
         || (cfg_index == mpva_pkg::REG_MODE && cfg_data[1:0] != mode_reg));
    assign clr_perf = clr_wheels
        || (cmd.op == mpva_pkg::OP_APPLY && st_reg[7:4] == mpva_pkg::MSG_CC
            && d1_reg == mpva_pkg::CC_ALL_OFF && d2_reg == 7'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg    <= 5'd0;
            vcount_reg    <= 5'd1;
            mode_reg      <= mpva_pkg::MODE_ROTATE;
            gaps_reg      <= 1'b0;
            for (int c = 0; c < NCH; c++)
            begin
                vn_reg[c]  <= mpva_pkg::NOTE_CENTER;
                vel_reg[c] <= 7'd0;
                prs_reg[c] <= 7'd0;
                bnd_reg[c] <= mpva_pkg::BEND_CENTER;
                mod_reg[c] <= 7'd0;
            end
            gate_reg      <= '0;
            gap_reg       <= '0;
            pedal_reg     <= 1'b0;
            ptr_reg       <= PTR_NONE;
            count_reg     <= '0;
            held_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            removed_reg   <= 7'd0;
            cnt_reg       <= 4'd0;
            rot_reg       <= 5'd0;
            vsel_reg      <= 4'd0;
            result_strobe <= 1'b0;
        end
        else
        begin
            result_strobe <= (cmd.op == mpva_pkg::OP_REC);
            if (cfg_wr)
            begin
                case (cfg_index)
                    mpva_pkg::REG_FILTER: filter_reg <= cfg_data;
                    mpva_pkg::REG_VOICES: vcount_reg <= cfg_data;
                    mpva_pkg::REG_MODE:   mode_reg   <= cfg_data[1:0];
                    default:              gaps_reg   <= cfg_data[0];
                endcase
            end
            case (cmd.op)
                mpva_pkg::OP_APPLY:
                begin
                    case (st_reg[7:4])
                        mpva_pkg::MSG_KEYP:
                        begin
                            for (int c = 0; c < NCH; c++)
                            begin
                                if (vmatch[c])
                                begin
                                    prs_reg[c] <= d2_reg;
                                end
                            end
                        end
                        mpva_pkg::MSG_CC:
                        begin
                            if (d1_reg == mpva_pkg::CC_MOD)
                            begin
                                mod_reg[mpe ? chan : 4'd0] <= d2_reg;
                            end
                            else if (d1_reg == mpva_pkg::CC_PEDAL)
                            begin
                                pedal_reg <= 1'b1;
                            end
                        end
                        mpva_pkg::MSG_CHP:
                        begin
                            for (int c = 0; c < NCH; c++)
                            begin
                                if (!mpe || 4'(c) == chan)
                                begin
                                    prs_reg[c] <= d1_reg;
                                end
                            end
                        end
                        mpva_pkg::MSG_BEND: bnd_reg[mpe ? chan : 4'd0] <= {d2_reg, d1_reg};
                        default: pedal_reg <= pedal_reg;
                    endcase
                end
                mpva_pkg::OP_RM_INIT:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                mpva_pkg::OP_RM_CHK:
                begin
                    if (is_match)
                    begin
                        found_reg   <= 1'b1;
                        removed_reg <= ram_q;
                    end
                    idx_reg <= idx_reg + IW'(1);
                end
                mpva_pkg::OP_RM_DONE:
                begin
                    if (found_reg)
                    begin
                        count_reg             <= count_reg - CW'(1);
                        held_reg[removed_reg] <= 1'b0;
                    end
                end
                mpva_pkg::OP_PUSH:
                begin
                    count_reg        <= count_reg + CW'(1);
                    held_reg[d1_reg] <= 1'b1;
                end
                mpva_pkg::OP_PICK:
                begin
                    rot_reg <= 5'd0;
                    if (mpe)
                    begin
                        vsel_reg <= chan;
                    end
                    else if (n_act == 5'd1)
                    begin
                        vsel_reg <= 4'd0;
                    end
                    else if (mode_reg == mpva_pkg::MODE_RESET)
                    begin
                        vsel_reg <= free_idx;
                    end
                    else
                    begin
                        vsel_reg <= reuse_idx;
                    end
                end
                mpva_pkg::OP_ROT:
                begin
                    ptr_reg  <= rot_step;
                    vsel_reg <= rot_step[3:0];
                    rot_reg  <= rot_reg + 5'd1;
                end
                mpva_pkg::OP_VSET:
                begin
                    vn_reg[vsel_reg]   <= d1_reg;
                    vel_reg[vsel_reg]  <= d2_reg;
                    gate_reg[vsel_reg] <= 1'b1;
                end
                mpva_pkg::OP_REL:
                begin
                    if (!pedal_reg)
                    begin
                        for (int c = 0; c < NCH; c++)
                        begin
                            if (vact[c] && vmatch[c])
                            begin
                                gate_reg[c] <= 1'b0;
                                gap_reg[c]  <= gaps_reg;
                            end
                        end
                    end
                end
                mpva_pkg::OP_TOP_WR:
                begin
                    vn_reg[0] <= ram_q;
                    if (kind == mpva_pkg::KIND_OFF)
                    begin
                        gate_reg[0] <= 1'b1;
                    end
                end
                mpva_pkg::OP_PED_INIT:
                begin
                    pedal_reg <= 1'b0;
                    cnt_reg   <= 4'd0;
                end
                mpva_pkg::OP_PED:
                begin
                    if (gate_reg[cnt_reg])
                    begin
                        gate_reg[cnt_reg] <= held_reg[vn_reg[cnt_reg]];
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                end
                mpva_pkg::OP_REC_INIT: cnt_reg <= 4'd0;
                mpva_pkg::OP_REC:
                begin
                    gap_reg[cnt_reg] <= 1'b0;
                    cnt_reg          <= cnt_reg + 4'd1;
                end
                default: cnt_reg <= cnt_reg;
            endcase
            if (clr_perf)
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    vn_reg[c]  <= mpva_pkg::NOTE_CENTER;
                    vel_reg[c] <= 7'd0;
                    prs_reg[c] <= 7'd0;
                    if (clr_wheels)
                    begin
                        bnd_reg[c] <= mpva_pkg::BEND_CENTER;
                        mod_reg[c] <= 7'd0;
                    end
                end
                gate_reg  <= '0;
                gap_reg   <= '0;
                pedal_reg <= 1'b0;
                ptr_reg   <= PTR_NONE;
                count_reg <= '0;
                held_reg  <= '0;
            end
        end
    end

    // message latch and record payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.op == mpva_pkg::OP_LATCH)
        begin
            st_reg <= status_byte;
            d1_reg <= data_first;
            d2_reg <= data_second;
        end
        if (cmd.op == mpva_pkg::OP_REC)
        begin
            voice          <= cnt_reg;
            note_number    <= vn_reg[cnt_reg];
            gate_on        <= gate_reg[cnt_reg] && !gap_reg[cnt_reg];
            note_velocity  <= vel_reg[cnt_reg];
            pressure       <= prs_reg[cnt_reg];
            bend           <= bnd_reg[w_idx];
            modulation     <= mod_reg[w_idx];
            start_event    <= (st_reg[7:4] == mpva_pkg::MSG_SYS && chan == mpva_pkg::SYS_START);
            stop_event     <= (st_reg[7:4] == mpva_pkg::MSG_SYS && chan == mpva_pkg::SYS_STOP);
            continue_event <= (st_reg[7:4] == mpva_pkg::MSG_SYS && chan == mpva_pkg::SYS_CONT);
            last           <= st.loop_last;
        end
    end

endmodule
